/* sv/bclru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap cache LRU lookup package
// Shared types, sizes and codes for the cache lookup unit.
// ----------------------------------------------------------------------------
package bclru_pkg;

	localparam int ENTRIES   = 1024;
	localparam int CLASSES   = 3;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int LINK_W    = IDX_W + 1;
	localparam int CLS_W     = 2;
	localparam int ADDR_W    = CLS_W + IDX_W;
	localparam int MEM_DEPTH = CLASSES * ENTRIES;
	localparam int LIMIT_W   = 27;
	localparam int COUNT_W   = 11;
	localparam int SIZE_W    = 28;
	localparam int GEOM_W    = 30;
	localparam int HASH_W    = 48;
	localparam int KEY_W     = 1 + HASH_W + GEOM_W;

	// link with the top bit set points nowhere
	localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {IDX_W{1'b0}}};

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CLASS0_LIMIT = 3'd0,
		REG_CLASS1_LIMIT = 3'd1,
		REG_CLASS2_LIMIT = 3'd2,
		REG_CLASS0_COUNT = 3'd3,
		REG_CLASS1_COUNT = 3'd4,
		REG_CLASS2_COUNT = 3'd5,
		REG_COMPRESSION  = 3'd6,
		REG_ORDER_VER    = 3'd7
	} cfg_idx_t;

	// order kinds
	localparam logic [2:0] ORD_NONE   = 3'd0;
	localparam logic [2:0] ORD_V3     = 3'd1;
	localparam logic [2:0] ORD_CMP_V2 = 3'd2;
	localparam logic [2:0] ORD_CMP_V1 = 3'd3;
	localparam logic [2:0] ORD_RAW_V2 = 3'd4;
	localparam logic [2:0] ORD_RAW_V1 = 3'd5;

	typedef struct packed {
		logic [11:0] pixel_width;
		logic [11:0] pixel_height;
		logic [5:0]  bits_per_pixel;
		logic [15:0] short_hash;
		logic [31:0] long_hash;
	} in_t;

	typedef struct packed {
		logic       too_big;
		logic       hit;
		logic [1:0] size_class;
		logic [9:0] slot;
		logic       evicted_valid;
		logic [2:0] order_kind;
	} out_t;

	// size unit result
	typedef struct packed {
		logic             too_big;
		logic [CLS_W-1:0] cls;
	} szc_res_t;

	typedef logic [LIMIT_W-1:0] limit_arr_t [CLASSES];

endpackage

/* sv/bclru_size_class.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap size classifier
// Padded byte size over two multiply steps, then picks the first class fit.
// ----------------------------------------------------------------------------
module bclru_size_class
	import bclru_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [11:0]      pixel_width,
	input  logic [11:0]      pixel_height,
	input  logic [5:0]       bits_per_pixel,
	input  limit_arr_t       limits,
	output logic             done,
	output szc_res_t         res
);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL1, ST_MUL2, ST_CMP} st_t;

	st_t               st_q;
	logic [12:0]       pad;
	logic [3:0]        bytes;
	logic [6:0]        bpp_sum;
	logic [24:0]       prod_q;
	logic [SIZE_W-1:0] size_q;
	logic [CLASSES-1:0] fits;
	logic              done_q;
	szc_res_t          res_q;

	// width rounded up to four, bytes per pixel rounded up
	assign pad     = ({1'b0, pixel_width} + 13'd3) & ~13'd3;
	assign bpp_sum = {1'b0, bits_per_pixel} + 7'd7;
	assign bytes   = bpp_sum[6:3];

	always_comb begin
		for (int c = 0; c < CLASSES; c++) begin
			fits[c] = size_q <= {{(SIZE_W-LIMIT_W){1'b0}}, limits[c]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (start) st_q <= ST_MUL1;
				end
				ST_MUL1: begin
					prod_q <= 25'(pad * pixel_height);
					st_q   <= ST_MUL2;
				end
				ST_MUL2: begin
					size_q <= SIZE_W'(prod_q * bytes);
					st_q   <= ST_CMP;
				end
				ST_CMP: begin
					done_q        <= 1'b1;
					res_q.too_big <= 1'b0;
					if (fits[0])      res_q.cls <= 2'd0;
					else if (fits[1]) res_q.cls <= 2'd1;
					else if (fits[2]) res_q.cls <= 2'd2;
					else begin
						res_q.cls     <= 2'd0;
						res_q.too_big <= 1'b1;
					end
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* sv/bitmap_cache_lru_lookup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap cache LRU lookup unit
// Size class pick, key scan over the class, LRU list update per item.
// ----------------------------------------------------------------------------
// After reset an initialisation sweep writes the link and key memories for all
// 3072 entries, one entry a cycle; items are not taken until it ends.
// An item that fits no class goes straight to the result. Otherwise the key
// scan reads one slot a cycle from the single key memory port and stops at
// the first hit or after the last slot of the class.
// One item at a time; the result register holds until taken.
module bitmap_cache_lru_lookup_unit
	import bclru_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [LIMIT_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SIZE, S_SCAN, S_TRIM, S_RD, S_UNLINK, S_LINK, S_FIN, S_OUT
	} state_t;

	state_t             state_q;
	in_t                item_q;
	limit_arr_t         limit_q;
	logic [COUNT_W-1:0] count_q [CLASSES];
	logic               comp_q;
	logic [2:0]         ver_q;
	logic [IDX_W-1:0]   head_q [CLASSES];
	logic [IDX_W-1:0]   tail_q [CLASSES];
	logic [CLASSES-1:0] trim_q;
	logic [ADDR_W-1:0]  init_q;
	logic [CLS_W-1:0]   cls_q;
	logic [IDX_W-1:0]   scan_q;
	logic               chk_vld_q;
	logic [IDX_W-1:0]   chk_idx_q;
	logic [IDX_W-1:0]   s_q;
	logic               hit_q;
	logic               mv_q;
	logic               ev_q;
	out_t               out_q;

	// memories
	logic [KEY_W-1:0]  key_mem [MEM_DEPTH];
	logic [LINK_W-1:0] nx_mem  [MEM_DEPTH];
	logic [LINK_W-1:0] pv_mem  [MEM_DEPTH];
	logic [KEY_W-1:0]  key_rd_q;
	logic [LINK_W-1:0] nx_rd_q;
	logic [LINK_W-1:0] pv_rd_q;

	logic              key_we, nx_we, pv_we;
	logic [ADDR_W-1:0] key_wa, key_ra, nx_wa, pv_wa, link_ra;
	logic [KEY_W-1:0]  key_wd;
	logic [LINK_W-1:0] nx_wd, pv_wd;

	logic              sz_start, sz_done;
	szc_res_t          sz_res;
	logic [GEOM_W-1:0] geom;
	logic [HASH_W-1:0] hashes;
	logic              key_match;
	logic [IDX_W-1:0]  init_idx;
	logic [COUNT_W-1:0] cnt_clamp;
	logic [IDX_W-1:0]  trim_last;
	logic [IDX_W-1:0]  cur_head, cur_tail;
	logic [2:0]        kind;

	bclru_size_class u_size (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (sz_start),
		.pixel_width    (item_q.pixel_width),
		.pixel_height   (item_q.pixel_height),
		.bits_per_pixel (item_q.bits_per_pixel),
		.limits         (limit_q),
		.done           (sz_done),
		.res            (sz_res)
	);

	assign sz_start  = (state_q == S_IDLE) && in_valid;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	assign geom   = {item_q.pixel_width, item_q.pixel_height, item_q.bits_per_pixel};
	assign hashes = {item_q.short_hash, item_q.long_hash};
	assign key_match = key_rd_q[KEY_W-1] && (key_rd_q[KEY_W-2:0] == {hashes, geom});
	assign init_idx  = init_q[IDX_W-1:0];
	assign cur_head  = head_q[cls_q];
	assign cur_tail  = tail_q[cls_q];

	// entry count clamped to 1..ENTRIES
	always_comb begin
		cnt_clamp = count_q[cls_q];
		if (cnt_clamp == '0) cnt_clamp = COUNT_W'(1);
		else if (cnt_clamp > COUNT_W'(ENTRIES)) cnt_clamp = COUNT_W'(ENTRIES);
		trim_last = IDX_W'(cnt_clamp - COUNT_W'(1));
	end

	// order kind from client capabilities
	always_comb begin
		kind = ORD_NONE;
		if (comp_q) begin
			if (ver_q[2])      kind = ORD_V3;
			else if (ver_q[1]) kind = ORD_CMP_V2;
			else if (ver_q[0]) kind = ORD_CMP_V1;
		end else begin
			if (ver_q[1])      kind = ORD_RAW_V2;
			else if (ver_q[0]) kind = ORD_RAW_V1;
		end
	end

	// memory port steering
	always_comb begin
		key_we  = 1'b0;
		key_wa  = {cls_q, s_q};
		key_wd  = {1'b1, hashes, geom};
		key_ra  = (state_q == S_SCAN) ? {cls_q, scan_q} : {cls_q, s_q};
		nx_we   = 1'b0;
		nx_wa   = {cls_q, s_q};
		nx_wd   = LINK_NONE;
		pv_we   = 1'b0;
		pv_wa   = {cls_q, s_q};
		pv_wd   = LINK_NONE;
		link_ra = {cls_q, s_q};
		case (state_q)
			S_INIT: begin
				key_we = 1'b1;
				key_wa = init_q;
				key_wd = '0;
				nx_we  = 1'b1;
				nx_wa  = init_q;
				nx_wd  = (init_idx == IDX_W'(ENTRIES - 1)) ? LINK_NONE
				         : {1'b0, init_idx + IDX_W'(1)};
				pv_we  = 1'b1;
				pv_wa  = init_q;
				pv_wd  = (init_idx == '0) ? LINK_NONE : {1'b0, init_idx - IDX_W'(1)};
			end
			S_TRIM: begin
				nx_we = 1'b1;
				nx_wa = {cls_q, trim_last};
				nx_wd = LINK_NONE;
			end
			S_UNLINK: begin
				if (mv_q) begin
					if (cur_head == s_q) begin
						pv_we = !nx_rd_q[IDX_W];
						pv_wa = {cls_q, nx_rd_q[IDX_W-1:0]};
						pv_wd = LINK_NONE;
					end else begin
						nx_we = !pv_rd_q[IDX_W];
						nx_wa = {cls_q, pv_rd_q[IDX_W-1:0]};
						nx_wd = nx_rd_q;
						pv_we = !nx_rd_q[IDX_W];
						pv_wa = {cls_q, nx_rd_q[IDX_W-1:0]};
						pv_wd = pv_rd_q;
					end
				end
			end
			S_LINK: begin
				nx_we = mv_q;
				nx_wa = {cls_q, cur_tail};
				nx_wd = {1'b0, s_q};
				pv_we = mv_q;
				pv_wa = {cls_q, s_q};
				pv_wd = {1'b0, cur_tail};
			end
			S_FIN: begin
				nx_we  = mv_q;
				nx_wa  = {cls_q, s_q};
				nx_wd  = LINK_NONE;
				key_we = !hit_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= key_wd;
		key_rd_q <= key_mem[key_ra];
	end

	always_ff @(posedge clk) begin
		if (nx_we) nx_mem[nx_wa] <= nx_wd;
		nx_rd_q <= nx_mem[link_ra];
	end

	always_ff @(posedge clk) begin
		if (pv_we) pv_mem[pv_wa] <= pv_wd;
		pv_rd_q <= pv_mem[link_ra];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLASSES; c++) begin
				limit_q[c] <= '0;
				count_q[c] <= COUNT_W'(ENTRIES);
			end
			comp_q <= 1'b0;
			ver_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				REG_CLASS0_LIMIT: limit_q[0] <= cfg_data;
				REG_CLASS1_LIMIT: limit_q[1] <= cfg_data;
				REG_CLASS2_LIMIT: limit_q[2] <= cfg_data;
				REG_CLASS0_COUNT: count_q[0] <= cfg_data[COUNT_W-1:0];
				REG_CLASS1_COUNT: count_q[1] <= cfg_data[COUNT_W-1:0];
				REG_CLASS2_COUNT: count_q[2] <= cfg_data[COUNT_W-1:0];
				REG_COMPRESSION:  comp_q     <= cfg_data[0];
				REG_ORDER_VER:    ver_q      <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			init_q    <= '0;
			chk_vld_q <= 1'b0;
			trim_q    <= '1;
			for (int c = 0; c < CLASSES; c++) begin
				head_q[c] <= '0;
				tail_q[c] <= IDX_W'(ENTRIES - 1);
			end
		end else begin
			case (state_q)
				S_INIT: begin
					init_q <= init_q + ADDR_W'(1);
					if (init_q == ADDR_W'(MEM_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= S_SIZE;
					end
				end
				S_SIZE: begin
					if (sz_done) begin
						cls_q     <= sz_res.cls;
						scan_q    <= '0;
						chk_vld_q <= 1'b0;
						if (sz_res.too_big) begin
							out_q         <= '0;
							out_q.too_big <= 1'b1;
							state_q       <= S_OUT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					scan_q    <= scan_q + IDX_W'(1);
					chk_idx_q <= scan_q;
					chk_vld_q <= 1'b1;
					if (chk_vld_q && key_match) begin
						chk_vld_q <= 1'b0;
						hit_q     <= 1'b1;
						s_q       <= chk_idx_q;
						state_q   <= S_RD;
					end else if (chk_vld_q && chk_idx_q == IDX_W'(ENTRIES - 1)) begin
						chk_vld_q <= 1'b0;
						hit_q     <= 1'b0;
						s_q       <= cur_head;
						state_q   <= trim_q[cls_q] ? S_TRIM : S_RD;
					end
				end
				S_TRIM: begin
					trim_q[cls_q] <= 1'b0;
					tail_q[cls_q] <= trim_last;
					state_q       <= S_RD;
				end
				S_RD: begin
					mv_q    <= (cur_tail != s_q);
					state_q <= S_UNLINK;
				end
				S_UNLINK: begin
					ev_q <= key_rd_q[KEY_W-1];
					if (mv_q && cur_head == s_q && !nx_rd_q[IDX_W]) begin
						head_q[cls_q] <= nx_rd_q[IDX_W-1:0];
					end
					state_q <= S_LINK;
				end
				S_LINK: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (mv_q) tail_q[cls_q] <= s_q;
					out_q.too_big    <= 1'b0;
					out_q.hit        <= hit_q;
					out_q.size_class <= cls_q;
					out_q.slot       <= s_q;
					out_q.evicted_valid <= hit_q ? 1'b0 : ev_q;
					out_q.order_kind <= hit_q ? ORD_NONE : kind;
					state_q          <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* tb/bitmap_cache_lru_lookup_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap cache LRU lookup checker
// Watches the item, result and register channels. It keeps its own copy of
// the cache keys, LRU links and registers, predicts each result and compares
// it with what the unit returns.
// ----------------------------------------------------------------------------
module bitmap_cache_lru_lookup_checker
	import bclru_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  in_t                in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  out_t               out_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [LIMIT_W-1:0] cfg_data,
	output int                 fails,
	output int                 pending
);

	// shadow registers
	logic [LIMIT_W-1:0] size_limit [CLASSES];
	logic [COUNT_W-1:0] entry_count [CLASSES];
	logic               compress_en;
	logic [2:0]         version_bits;

	// shadow cache: key, valid flag and LRU links (-1 is no link)
	logic [77:0] key_mem   [MEM_DEPTH];
	bit          valid_mem [MEM_DEPTH];
	int          next_link [MEM_DEPTH];
	int          prev_link [MEM_DEPTH];
	int          lru_first [CLASSES];
	int          lru_last  [CLASSES];
	bit          trim_due  [CLASSES];

	out_t result_q [$];
	out_t exp_res;

	// unlink slot s of class c and append it at the tail
	function automatic void promote_slot(int c, int s);
		int b;
		int t;
		int nx;
		int pv;
		b = c * ENTRIES;
		t = lru_last[c];
		if (t == s)
			return;
		nx = next_link[b + s];
		if (lru_first[c] == s) begin
			if (nx >= 0) begin
				prev_link[b + nx] = -1;
				lru_first[c] = nx;
			end
		end else begin
			pv = prev_link[b + s];
			if (pv >= 0)
				next_link[b + pv] = nx;
			if (nx >= 0)
				prev_link[b + nx] = pv;
		end
		if (t >= 0)
			next_link[b + t] = s;
		prev_link[b + s] = t;
		next_link[b + s] = -1;
		lru_last[c] = s;
	endfunction

	function automatic logic [2:0] order_for_client();
		if (compress_en) begin
			if (version_bits[2]) return ORD_V3;
			if (version_bits[1]) return ORD_CMP_V2;
			if (version_bits[0]) return ORD_CMP_V1;
			return ORD_NONE;
		end
		if (version_bits[1]) return ORD_RAW_V2;
		if (version_bits[0]) return ORD_RAW_V1;
		return ORD_NONE;
	endfunction

	// look up one descriptor and update the shadow cache
	function automatic out_t lookup_bitmap(in_t d);
		out_t r;
		logic [77:0] key;
		int unsigned size;
		int c;
		int b;
		int i;
		int cnt;
		int s;
		r = '0;
		key = {d.short_hash, d.long_hash, d.pixel_width, d.pixel_height, d.bits_per_pixel};
		size = ((int'(d.pixel_width) + 3) & ~3) * int'(d.pixel_height)
			* ((int'(d.bits_per_pixel) + 7) >> 3);
		c = 0;
		while (c < CLASSES && size > size_limit[c])
			c++;
		if (c >= CLASSES) begin
			r.too_big = 1'b1;
			return r;
		end
		b = c * ENTRIES;
		r.size_class = c[1:0];
		for (i = 0; i < ENTRIES; i++) begin
			if (valid_mem[b + i] && key_mem[b + i] == key) begin
				promote_slot(c, i);
				r.hit = 1'b1;
				r.slot = i[9:0];
				return r;
			end
		end
		// first miss after reset cuts the list to the entry count
		if (trim_due[c]) begin
			trim_due[c] = 0;
			cnt = entry_count[c];
			if (cnt < 1) cnt = 1;
			if (cnt > ENTRIES) cnt = ENTRIES;
			lru_last[c] = cnt - 1;
			next_link[b + cnt - 1] = -1;
		end
		s = lru_first[c];
		if (s < 0 || s >= ENTRIES)
			s = 0;
		promote_slot(c, s);
		r.evicted_valid = valid_mem[b + s];
		key_mem[b + s] = key;
		valid_mem[b + s] = 1;
		r.slot = s[9:0];
		r.order_kind = order_for_client();
		return r;
	endfunction

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fails = 0;
			result_q.delete();
			for (int c = 0; c < CLASSES; c++) begin
				size_limit[c] = '0;
				entry_count[c] = COUNT_W'(1024);
				lru_first[c] = 0;
				lru_last[c] = ENTRIES - 1;
				trim_due[c] = 1;
				for (int i = 0; i < ENTRIES; i++) begin
					valid_mem[c * ENTRIES + i] = 0;
					next_link[c * ENTRIES + i] = (i + 1 < ENTRIES) ? i + 1 : -1;
					prev_link[c * ENTRIES + i] = (i > 0) ? i - 1 : -1;
				end
			end
			compress_en = 1'b0;
			version_bits = '0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CLASS0_LIMIT: size_limit[0] = cfg_data;
					REG_CLASS1_LIMIT: size_limit[1] = cfg_data;
					REG_CLASS2_LIMIT: size_limit[2] = cfg_data;
					REG_CLASS0_COUNT: entry_count[0] = cfg_data[COUNT_W-1:0];
					REG_CLASS1_COUNT: entry_count[1] = cfg_data[COUNT_W-1:0];
					REG_CLASS2_COUNT: entry_count[2] = cfg_data[COUNT_W-1:0];
					REG_COMPRESSION:  compress_en = cfg_data[0];
					REG_ORDER_VER:    version_bits = cfg_data[2:0];
					default: ;
				endcase
			end
			// results belong to earlier items, so compare before predicting
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result %h", out_data);
				end else begin
					exp_res = result_q.pop_front();
					if (out_data.too_big !== exp_res.too_big
						|| out_data.hit !== exp_res.hit
						|| out_data.size_class !== exp_res.size_class
						|| out_data.slot !== exp_res.slot
						|| out_data.evicted_valid !== exp_res.evicted_valid
						|| out_data.order_kind !== exp_res.order_kind) begin
						fails++;
						if (fails <= 10)
							$display("result differs: expected %p, got %p", exp_res, out_data);
					end
				end
			end
			if (in_valid && in_ready)
				result_q.push_back(lookup_bitmap(in_data));
		end
	end

endmodule

/* tb/bitmap_cache_lru_lookup_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap cache LRU lookup unit testbench
// Directed descriptors, then phases of random ones under several register
// settings, with random gaps on both channels; the checker does the scoring.
// ----------------------------------------------------------------------------
module bitmap_cache_lru_lookup_unit_tb;
	import bclru_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	in_t                in_data;
	logic               out_valid;
	logic               out_ready;
	out_t               out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [LIMIT_W-1:0] cfg_data;
	int                 fails;
	int                 pending;

	bit   burst_mode;
	int   results_taken;
	in_t  recent_keys [$];

	localparam logic [LIMIT_W-1:0] LIM_MAX = {LIMIT_W{1'b1}};

	bitmap_cache_lru_lookup_unit uut (.*);

	bitmap_cache_lru_lookup_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("bitmap_cache_lru_lookup_unit: mismatch");
		$finish;
	end

	// register write, one item on the config channel
	task automatic write_reg(cfg_idx_t idx, logic [LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, then wait for every outstanding result
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_phase(logic [LIMIT_W-1:0] l0, l1, l2, c0, c1, c2,
			logic comp, logic [2:0] ver);
		wait_idle();
		write_reg(REG_CLASS0_LIMIT, l0);
		write_reg(REG_CLASS1_LIMIT, l1);
		write_reg(REG_CLASS2_LIMIT, l2);
		write_reg(REG_CLASS0_COUNT, c0);
		write_reg(REG_CLASS1_COUNT, c1);
		write_reg(REG_CLASS2_COUNT, c2);
		write_reg(REG_COMPRESSION, LIMIT_W'(comp));
		write_reg(REG_ORDER_VER, LIMIT_W'(ver));
	endtask

	// offer one descriptor after a gap; valid stays high on back-to-back items
	task automatic send_item(in_t d);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(6);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do @(posedge clk); while (!in_ready);
		recent_keys.push_back(d);
		if (recent_keys.size() > 24)
			void'(recent_keys.pop_front());
	endtask

	task automatic put(int w, int h, int bpp, int sh, logic [31:0] lh);
		in_t d;
		d.pixel_width    = w[11:0];
		d.pixel_height   = h[11:0];
		d.bits_per_pixel = bpp[5:0];
		d.short_hash     = sh[15:0];
		d.long_hash      = lh;
		send_item(d);
	endtask

	// mostly repeats and small bitmaps so that hits and evictions are frequent
	function automatic in_t make_item();
		in_t d;
		int r;
		r = $urandom_range(99);
		d = in_t'({$urandom, $urandom, $urandom});
		if (r < 45 && recent_keys.size() > 0) begin
			d = recent_keys[$urandom_range(recent_keys.size() - 1)];
		end else if (r < 70) begin
			d.pixel_width    = 12'($urandom_range(63));
			d.pixel_height   = 12'($urandom_range(31));
			d.short_hash     = 16'($urandom_range(3));
			d.long_hash      = 32'($urandom_range(3));
		end else if (r >= 85) begin
			d.bits_per_pixel = 6'd32;
		end
		return d;
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				burst_mode = ($urandom_range(3) == 0);
			send_item(make_item());
		end
	endtask

	// receiver: random holds, one long hold to fill the unit up
	initial begin
		int gap;
		out_ready = 1'b0;
		results_taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = burst_mode ? 0 : $urandom_range(6);
			if (results_taken == 150)
				gap = 3000;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			results_taken++;
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CLASS0_LIMIT;
		cfg_data  = '0;
		burst_mode = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// counts only take effect at the first miss: 4, clamped up to 1, clamped to max
		set_phase(4096, 65536, LIM_MAX, 4, 0, 2047, 1'b0, 3'd3);

		// directed: size zero, extremes, repeats for hits, single slot class
		put(0, 0, 0, 0, 32'h0);
		put(0, 0, 0, 0, 32'h0);
		put(4095, 4095, 32, 16'hffff, 32'hffffffff);
		put(4095, 4095, 32, 16'hffff, 32'hffffffff);
		put(4095, 4095, 63, 16'h8000, 32'h80000000);
		put(1, 1, 1, 1, 32'h1);
		put(2, 1, 8, 1, 32'h1);
		put(3, 3, 16, 2, 32'h2);
		put(4, 4, 24, 3, 32'h3);
		put(5, 2, 8, 4, 32'h4);
		put(1, 1, 1, 1, 32'h1);
		put(100, 100, 8, 7, 32'h7);
		put(100, 100, 8, 7, 32'h7);
		put(100, 100, 8, 8, 32'h7);
		put(100, 100, 9, 8, 32'h7);
		put(0, 4095, 63, 16'h5555, 32'haaaaaaaa);
		put(4095, 0, 1, 16'haaaa, 32'h55555555);
		put(64, 64, 8, 0, 32'h0);
		put(64, 64, 8, 0, 32'h1);

		random_items(110);
		// sender holds back until the unit has drained
		wait_idle();
		random_items(20);

		// all limits zero: only size zero fits, the rest is too big
		set_phase(0, 0, 0, 1, 1024, 1, 1'b1, 3'd7);
		random_items(100);
		set_phase(2000, 50000, 5000000, LIM_MAX, 12, 3, 1'b1, 3'd2);
		random_items(120);
		set_phase(LIM_MAX, LIM_MAX, LIM_MAX, 0, 5, 6, 1'b1, 3'd1);
		random_items(100);
		set_phase(300, 300, 40000, 2, 2, 2, 1'b0, 3'd1);
		random_items(120);
		set_phase(1000, 100000, 1000000, 7, 7, 7, 1'b1, 3'd0);
		random_items(120);
		set_phase(50000, 60000, 70000000, 9, 9, 9, 1'b0, 3'd4);
		random_items(120);

		wait_idle();
		repeat (50) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("bitmap_cache_lru_lookup_unit: match");
		end else begin
			$display("bitmap_cache_lru_lookup_unit: mismatch");
		end
		$finish;
	end

endmodule
